// ===== hw/rtl/a85_pkg.sv =====
// Shared types and constants of the ASCII85 stream decoder.
`default_nettype none

package a85_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FIRST = 8'h21;  // '!', digit value 0
  localparam logic [7:0] CH_LAST  = 8'h75;  // 'u', digit value 84
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam logic [6:0]  DIGIT_BIAS = 7'd33;
  localparam logic [31:0] RADIX      = 32'd85;
  localparam logic [31:0] PAD_DIGIT  = 32'd84;
  localparam logic [2:0]  GROUP_LEN  = 3'd5;
  localparam logic [2:0]  GROUP_BYTES = 3'd4;

  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_FINISH  = 3'd1,
    ST_BAD_END = 3'd2,
    ST_Z_GROUP = 3'd3,
    ST_RANGE   = 3'd4
  } a85_status_t;

  typedef enum logic [2:0] {
    ACC_HOLD  = 3'd0,
    ACC_CLEAR = 3'd1,
    ACC_DIGIT = 3'd2,
    ACC_PAD   = 3'd3,
    ACC_SHIFT = 3'd4
  } a85_acc_op_t;

  typedef enum logic [1:0] {
    PH_NORM  = 2'd0,
    PH_TILDE = 2'd1,
    PH_END   = 2'd2
  } a85_phase_t;

  // controller -> datapath
  typedef struct packed {
    a85_acc_op_t acc_op;
    logic        cnt_inc;
    logic        cnt_clr;
    logic        out_load;
    logic        out_sel_acc;
    a85_status_t out_status;
    logic        out_last;
  } a85_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cnt;
    logic       out_free;
  } a85_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/a85_dp.sv =====
// Datapath: group accumulator, digit count and output beat register.
`default_nettype none

module a85_dp
  import a85_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_char,
  input  wire a85_cmd_t    cmd,
  output a85_stat_t        stat,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic [2:0]       out_tuser,
  output logic             out_tlast
);

  logic [31:0] acc_r, acc_nxt;
  logic [31:0] acc_base;
  logic [6:0]  digit;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  a85_status_t status_r;
  logic        last_r;

  // a new group starts from zero
  assign acc_base = (cnt_r == 3'd0) ? 32'd0 : acc_r;
  assign digit    = in_char[6:0] - DIGIT_BIAS;

  always_comb begin
    case (cmd.acc_op)
      ACC_CLEAR: acc_nxt = 32'd0;
      ACC_DIGIT: acc_nxt = acc_base * RADIX + {25'd0, digit};
      ACC_PAD:   acc_nxt = acc_r * RADIX + PAD_DIGIT;
      ACC_SHIFT: acc_nxt = {acc_r[23:0], 8'd0};
      default:   acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = 3'd0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 3'd1;
    end
  end

  assign stat.cnt      = cnt_r;
  assign stat.out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.out_load) begin
      out_byte_r <= cmd.out_sel_acc ? acc_r[31:24] : 8'd0;
      status_r   <= cmd.out_status;
      last_r     <= cmd.out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = status_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/a85_ctrl.sv =====
// Controller: character decode, end sequence, error halt and beat sequencing.
`default_nettype none

module a85_ctrl
  import a85_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_char,
  input  wire logic        in_finish,
  input  wire a85_stat_t   stat,
  output a85_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PAD  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  a85_phase_t phase_r, phase_nxt;
  logic       halt_r, halt_nxt;
  logic [2:0] pad_r, pad_nxt;
  logic [2:0] emit_r, emit_nxt;
  logic       marker_r, marker_nxt;
  logic       in_fire;
  logic       is_space;

  assign in_tready = (state_r == S_IDLE) && stat.out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign is_space  = (in_char == CH_SPACE) || (in_char == CH_TAB) || (in_char == CH_LF) ||
                     (in_char == CH_VT) || (in_char == CH_FF) || (in_char == CH_CR);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    halt_nxt       = halt_r;
    pad_nxt        = pad_r;
    emit_nxt       = emit_r;
    marker_nxt     = marker_r;
    cmd.acc_op     = ACC_HOLD;
    cmd.cnt_inc    = 1'b0;
    cmd.cnt_clr    = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.out_sel_acc = 1'b0;
    cmd.out_status = ST_DATA;
    cmd.out_last   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_finish) begin
            if (!halt_r && stat.cnt != 3'd0) begin
              // pad the partial group, then its bytes, then the marker
              cmd.cnt_clr = 1'b1;
              pad_nxt     = GROUP_LEN - stat.cnt;
              emit_nxt    = stat.cnt - 3'd1;
              marker_nxt  = 1'b1;
              state_nxt   = S_PAD;
            end else begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_FINISH;
              cmd.out_last   = 1'b1;
            end
          end else if (halt_r || phase_r == PH_END) begin
            // drop the character
          end else if (phase_r == PH_TILDE) begin
            if (in_char == CH_GT) begin
              phase_nxt = PH_END;
              if (stat.cnt != 3'd0) begin
                cmd.cnt_clr = 1'b1;
                pad_nxt     = GROUP_LEN - stat.cnt;
                emit_nxt    = stat.cnt - 3'd1;
                marker_nxt  = 1'b0;
                state_nxt   = S_PAD;
              end
            end else begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_BAD_END;
              cmd.out_last   = 1'b1;
              halt_nxt       = 1'b1;
            end
          end else if (is_space) begin
            // skip whitespace
          end else if (in_char == CH_TILDE) begin
            phase_nxt = PH_TILDE;
          end else if (in_char == CH_Z) begin
            if (stat.cnt != 3'd0) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_Z_GROUP;
              cmd.out_last   = 1'b1;
              halt_nxt       = 1'b1;
            end else begin
              cmd.acc_op = ACC_CLEAR;
              emit_nxt   = GROUP_BYTES;
              marker_nxt = 1'b0;
              state_nxt  = S_EMIT;
            end
          end else if (in_char < CH_FIRST || in_char > CH_LAST) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_RANGE;
            cmd.out_last   = 1'b1;
            halt_nxt       = 1'b1;
          end else begin
            cmd.acc_op = ACC_DIGIT;
            if (stat.cnt == GROUP_LEN - 3'd1) begin
              cmd.cnt_clr = 1'b1;
              emit_nxt    = GROUP_BYTES;
              marker_nxt  = 1'b0;
              state_nxt   = S_EMIT;
            end else begin
              cmd.cnt_inc = 1'b1;
            end
          end
        end
      end

      S_PAD: begin
        cmd.acc_op = ACC_PAD;
        pad_nxt    = pad_r - 3'd1;
        if (pad_r == 3'd1) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (emit_r != 3'd0) begin
          if (stat.out_free) begin
            cmd.out_load    = 1'b1;
            cmd.out_sel_acc = 1'b1;
            cmd.out_status  = ST_DATA;
            cmd.out_last    = (emit_r == 3'd1) && !marker_r;
            cmd.acc_op      = ACC_SHIFT;
            emit_nxt        = emit_r - 3'd1;
            if (emit_r == 3'd1 && !marker_r) begin
              state_nxt = S_IDLE;
            end
          end
        end else if (marker_r) begin
          if (stat.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_FINISH;
            cmd.out_last   = 1'b1;
            marker_nxt     = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_NORM;
      halt_r   <= 1'b0;
      pad_r    <= 3'd0;
      emit_r   <= 3'd0;
      marker_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      halt_r   <= halt_nxt;
      pad_r    <= pad_nxt;
      emit_r   <= emit_nxt;
      marker_r <= marker_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ascii85_stream_decoder.sv =====
// Top level of the ASCII85 stream decoder: controller plus datapath.
//   Input channel in_*: one beat per character (in_tuser = 0, character in
//   in_tdata) or a finish request (in_tuser = 1, in_tdata ignored).
//   Output channel out_*: one beat per decoded byte or status; out_tuser is
//   the status code, out_tdata the byte (zero on status beats), out_tlast
//   marks the final beat produced by an input beat.
//   An input beat is taken when the controller is idle and the output
//   register is empty or draining; digits, whitespace and dropped
//   characters free the input again on the next cycle.
//   A completed group or a 'z' holds the input while its four bytes enter
//   the output register, one per cycle unless the receiver stalls. A finish
//   or a '~>' flush of a partial group of n digits pads the accumulator to
//   five digits (one multiply-by-85 per cycle), then gives n-1 byte beats,
//   then the finished marker for a finish request.
//   An error or a finish on an empty group loads its beat at once, seen on
//   the next cycle; a full group or a 'z' first enters the emit state.
//   After any error, drop characters until reset; finish still answers.
//   Reset (rst_n low, synchronous) empties the group, clears end and error
//   state and drops any pending output beat. When the receiver stalls, hold
//   the output beat and stop taking input beats.
`default_nettype none

module ascii85_stream_decoder
  import a85_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tuser,   // [0] action: 0 character, 1 finish
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [2:0]      out_tuser,  // [2:0] status
  output logic            out_tlast   // last result of the input beat
);

  a85_cmd_t  cmd;
  a85_stat_t stat;

  // sequence beats, decode characters, track end sequence and errors
  a85_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_char   (in_tdata),
    .in_finish (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  // accumulate base-85 digits and hold the output beat
  a85_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/a85_chk.sv =====
// Port-level assertions for the ASCII85 stream decoder, bound to the top level.
`default_nettype none

module a85_chk
  import a85_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [2:0] out_tuser,
  input wire logic       out_tlast
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output beat changed");

  // status beats carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DATA |-> out_tdata == 8'd0)
    else $error("status beat with nonzero data");

  // finished marker and errors always close the beats of their input
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DATA |-> out_tlast)
    else $error("status beat without tlast");

  // no status code beyond the defined ones
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ST_DATA || out_tuser == ST_FINISH ||
      out_tuser == ST_BAD_END || out_tuser == ST_Z_GROUP || out_tuser == ST_RANGE)
    else $error("undefined status code");

  // stop taking input beats while a stalled output beat waits
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input beat taken while output stalled");

endmodule

bind ascii85_stream_decoder a85_chk u_a85_chk (.*);

`default_nettype wire
